### sv/assert_macros.svh
// Assertion macros shared by the literal range encoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// condition implies consequence in the same cycle
`define LZR_ASSERT_NOW(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("assertion failed");
// condition implies consequence in the next cycle
`define LZR_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("assertion failed");
`endif

### sv/lzr_pkg.sv
// Shared types and constants of the literal range encoder
package lzr_pkg;

  localparam logic [31:0] RANGE_TOP     = 32'h0100_0000;
  localparam logic [31:0] RANGE_INIT    = 32'hFFFF_FFFF;
  localparam logic [31:0] PEND_MAX      = 32'hFFFF_FFFF;
  localparam int          LIT_TREE_SIZE = 'h300;
  localparam logic [2:0]  FLUSH_LAST    = 3'd4;
  localparam logic [3:0]  MATCH_BIT     = 4'd8;
  localparam logic [7:0]  FILL_NO_CARRY = 8'hFF;
  localparam logic [7:0]  FILL_CARRY    = 8'h00;

  typedef struct packed {
    logic [7:0]  lead_byte;
    logic [7:0]  fill_byte;
    logic [31:0] fill_count;
  } res_t;

  typedef struct packed {
    res_t       res;
    logic       last_of_run;
  } out_beat_t;

  typedef struct packed {
    logic emit;
    logic close;
  } ostage_ctrl_t;

  typedef struct packed {
    logic stall;
  } ostage_stat_t;

endpackage

### sv/lzr_if.sv
// Channel interfaces of the literal range encoder
interface lzr_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;
  modport source (output valid, output opcode, output data_byte, input ready);
  modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface lzr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  lead_byte;
  logic [7:0]  fill_byte;
  logic [31:0] fill_count;
  logic        last_of_run;
  modport source (output valid, output lead_byte, output fill_byte, output fill_count,
                  output last_of_run, input ready);
  modport sink (input valid, input lead_byte, input fill_byte, input fill_count,
                input last_of_run, output ready);
endinterface

### sv/lzr_prob_ram.sv
// Probability memory, one write port and one registered read port
module lzr_prob_ram #(
  parameter int DEPTH = 6144,
  parameter int AW    = 13,
  parameter int DW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

### sv/lzr_out_stage.sv
// Result staging: holds the newest result until the item's last one is known
module lzr_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lzr_pkg::ostage_ctrl_t ctrl,
  input  lzr_pkg::res_t        res,
  output lzr_pkg::ostage_stat_t stat,
  lzr_out_if.source            out_ch
);
  import lzr_pkg::*;

  logic      hold_v_r, hold_v_nxt;
  res_t      hold_r, hold_nxt;
  logic      out_v_r, out_v_nxt;
  out_beat_t out_r, out_nxt;
  logic      can_take;
  logic      stall;

  assign can_take = !out_v_r || out_ch.ready;
  assign stall    = (ctrl.emit || ctrl.close) && hold_v_r && !can_take;
  assign stat.stall = stall;

  always_comb begin
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    out_v_nxt  = out_v_r;
    out_nxt    = out_r;
    if (out_v_r && out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
    if (!stall) begin
      if (ctrl.emit) begin
        if (hold_v_r) begin
          out_nxt   = '{res: hold_r, last_of_run: 1'b0};
          out_v_nxt = 1'b1;
        end
        hold_nxt   = res;
        hold_v_nxt = 1'b1;
      end else if (ctrl.close && hold_v_r) begin
        out_nxt    = '{res: hold_r, last_of_run: 1'b1};
        out_v_nxt  = 1'b1;
        hold_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.lead_byte   = out_r.res.lead_byte;
  assign out_ch.fill_byte   = out_r.res.fill_byte;
  assign out_ch.fill_count  = out_r.res.fill_count;
  assign out_ch.last_of_run = out_r.last_of_run;
endmodule

### sv/lzma_literal_range_encoder_core.sv
// Top level: sequencer and shared multiply/shift datapath of the literal range encoder
// Data byte: 9 coded bits, each through read, multiply, update and normalize states,
//   normalize repeating once per extra byte shift; one item at a time.
// Finish: 5 byte shifts and a close step, then a clearing pass over all
//   0x300 << LIT_CONTEXT_BITS entries (6144 by default) of the probability memory.
// Reset (synchronous, rst_n low) starts the same clearing pass; no beat is taken meanwhile.
// Output stalls hold the sequencer only when a result must move into a full output register.
module lzma_literal_range_encoder_core #(
  parameter int LIT_CONTEXT_BITS = 3,
  parameter int POS_BITS         = 2,
  parameter int PROB_BITS        = 11,
  parameter int ADAPT_SHIFT      = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  lzr_in_if.sink     in_ch,
  lzr_out_if.source  out_ch
);
  import lzr_pkg::*;

  `include "assert_macros.svh"

  localparam int NM   = 1 << POS_BITS;
  localparam int PW   = (POS_BITS > 0) ? POS_BITS : 1;
  localparam int NLIT = LIT_TREE_SIZE << LIT_CONTEXT_BITS;
  localparam int AW   = $clog2(NLIT);
  localparam int PB   = PROB_BITS;
  localparam logic [PB-1:0] PROB_MID = PB'(1 << (PB - 1));
  localparam logic [PB:0]   PROB_ONE = (PB + 1)'(1 << PB);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_UPD   = 4'd4;
  localparam logic [3:0] S_NORM  = 4'd5;
  localparam logic [3:0] S_FLUSH = 4'd6;
  localparam logic [3:0] S_END   = 4'd7;

  logic [3:0]    state_r, state_nxt;
  logic [32:0]   low_r, low_nxt;
  logic [31:0]   range_r, range_nxt;
  logic [7:0]    cache_r, cache_nxt;
  logic [31:0]   pend_r, pend_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PB-1:0] match_r [NM];
  logic [PB-1:0] match_nxt [NM];
  logic          fin_r, fin_nxt;
  logic [7:0]    sym_r, sym_nxt;
  logic [3:0]    bitn_r, bitn_nxt;
  logic [7:0]    ctx_r, ctx_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [PB-1:0] p_r, p_nxt;
  logic [31:0]   bound_r, bound_nxt;
  logic [2:0]    fcnt_r, fcnt_nxt;
  logic [AW-1:0] clr_r, clr_nxt;

  logic [AW-1:0]    lit_addr;
  logic [PB-1:0]    ram_q;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [PB-1:0]    ram_wdata;
  logic [PB-1:0]    p_sel;
  logic [31-PB:0]   range_hi;
  logic             bitv;
  logic [PB-1:0]    p_new;
  logic             sh_hi;
  logic             do_shift;
  logic             emit;
  logic             stall;
  logic             in_acc;
  ostage_ctrl_t     os_ctrl;
  ostage_stat_t     os_stat;
  res_t             sh_res;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign lit_addr = base_r + AW'(ctx_r);
  assign p_sel    = (bitn_r == MATCH_BIT) ? match_r[pos_r] : ram_q;
  assign range_hi = range_r[31:PB];
  assign bitv     = (bitn_r == MATCH_BIT) ? 1'b0 : sym_r[bitn_r[2:0]];
  assign p_new    = bitv ? (p_r - (p_r >> ADAPT_SHIFT))
                         : (p_r + PB'((PROB_ONE - {1'b0, p_r}) >> ADAPT_SHIFT));

  // byte shift unit, shared by normalization and flush
  assign sh_hi    = low_r[32];
  assign do_shift = ((state_r == S_NORM) && (range_r < RANGE_TOP)) || (state_r == S_FLUSH);
  assign emit     = do_shift && (sh_hi || (low_r[31:24] != 8'hFF));
  assign sh_res.lead_byte  = cache_r + {7'd0, sh_hi};
  assign sh_res.fill_byte  = sh_hi ? FILL_CARRY : FILL_NO_CARRY;
  assign sh_res.fill_count = (pend_r != 32'd0) ? (pend_r - 32'd1) : 32'd0;

  assign os_ctrl.emit  = emit;
  assign os_ctrl.close = (state_r == S_END);
  assign stall         = os_stat.stall;

  assign ram_we    = (state_r == S_CLR) || ((state_r == S_UPD) && (bitn_r != MATCH_BIT));
  assign ram_waddr = (state_r == S_CLR) ? clr_r : lit_addr;
  assign ram_wdata = (state_r == S_CLR) ? PROB_MID : p_new;

  always_comb begin
    state_nxt = state_r;
    low_nxt   = low_r;
    range_nxt = range_r;
    cache_nxt = cache_r;
    pend_nxt  = pend_r;
    prev_nxt  = prev_r;
    pos_nxt   = pos_r;
    for (int i = 0; i < NM; i++) begin
      match_nxt[i] = match_r[i];
    end
    fin_nxt   = fin_r;
    sym_nxt   = sym_r;
    bitn_nxt  = bitn_r;
    ctx_nxt   = ctx_r;
    base_nxt  = base_r;
    p_nxt     = p_r;
    bound_nxt = bound_r;
    fcnt_nxt  = fcnt_r;
    clr_nxt   = clr_r;

    if (do_shift && !stall) begin
      if (sh_hi || (low_r[31:24] != 8'hFF)) begin
        cache_nxt = low_r[31:24];
        pend_nxt  = 32'd1;
      end else if (pend_r != PEND_MAX) begin
        pend_nxt  = pend_r + 32'd1;
      end
      low_nxt = {1'b0, low_r[23:0], 8'h00};
    end

    case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(NLIT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          fin_nxt  = in_ch.opcode;
          sym_nxt  = in_ch.data_byte;
          bitn_nxt = MATCH_BIT;
          ctx_nxt  = 8'd1;
          fcnt_nxt = 3'd0;
          base_nxt = AW'(LIT_TREE_SIZE * (32'(prev_r) >> (8 - LIT_CONTEXT_BITS)));
          state_nxt = in_ch.opcode ? S_FLUSH : S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        p_nxt     = p_sel;
        bound_nxt = 32'(range_hi) * 32'(p_sel);
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (bitv) begin
          low_nxt   = low_r + {1'b0, bound_r};
          range_nxt = range_r - bound_r;
        end else begin
          range_nxt = bound_r;
        end
        if (bitn_r == MATCH_BIT) begin
          match_nxt[pos_r] = p_new;
        end else begin
          ctx_nxt = {ctx_r[6:0], bitv};
        end
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (range_r < RANGE_TOP) begin
          if (!stall) begin
            range_nxt = {range_r[23:0], 8'h00};
          end
        end else if (bitn_r == 4'd0) begin
          state_nxt = S_END;
        end else begin
          bitn_nxt  = bitn_r - 4'd1;
          state_nxt = S_RD;
        end
      end
      S_FLUSH: begin
        if (!stall) begin
          fcnt_nxt = fcnt_r + 3'd1;
          if (fcnt_r == FLUSH_LAST) begin
            state_nxt = S_END;
          end
        end
      end
      S_END: begin
        if (!stall) begin
          if (fin_r) begin
            low_nxt   = '0;
            range_nxt = RANGE_INIT;
            cache_nxt = 8'd0;
            pend_nxt  = 32'd1;
            prev_nxt  = 8'd0;
            pos_nxt   = '0;
            for (int i = 0; i < NM; i++) begin
              match_nxt[i] = PROB_MID;
            end
            clr_nxt   = '0;
            state_nxt = S_CLR;
          end else begin
            prev_nxt  = sym_r;
            pos_nxt   = PW'((32'(pos_r) + 32'd1) % NM);
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_CLR;
        clr_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      low_r   <= '0;
      range_r <= RANGE_INIT;
      cache_r <= 8'd0;
      pend_r  <= 32'd1;
      prev_r  <= 8'd0;
      pos_r   <= '0;
      fin_r   <= 1'b0;
      for (int i = 0; i < NM; i++) begin
        match_r[i] <= PROB_MID;
      end
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      low_r   <= low_nxt;
      range_r <= range_nxt;
      cache_r <= cache_nxt;
      pend_r  <= pend_nxt;
      prev_r  <= prev_nxt;
      pos_r   <= pos_nxt;
      fin_r   <= fin_nxt;
      for (int i = 0; i < NM; i++) begin
        match_r[i] <= match_nxt[i];
      end
    end
    sym_r   <= sym_nxt;
    bitn_r  <= bitn_nxt;
    ctx_r   <= ctx_nxt;
    base_r  <= base_nxt;
    p_r     <= p_nxt;
    bound_r <= bound_nxt;
    fcnt_r  <= fcnt_nxt;
  end

  lzr_prob_ram #(
    .DEPTH (NLIT),
    .AW    (AW),
    .DW    (PB)
  ) u_prob_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (lit_addr),
    .rdata (ram_q)
  );

  lzr_out_stage u_out_stage (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (os_ctrl),
    .res    (sh_res),
    .stat   (os_stat),
    .out_ch (out_ch)
  );

  `LZR_ASSERT_NOW(a_idle_range_norm, state_r == S_IDLE, range_r >= RANGE_TOP)
  `LZR_ASSERT_NOW(a_idle_pend_nonzero, state_r == S_IDLE, pend_r != 32'd0)
  `LZR_ASSERT_NEXT(a_finish_to_clear, (state_r == S_END) && fin_r && !stall, (state_r == S_CLR) && (clr_r == '0))
  `LZR_ASSERT_NOW(a_bit_index_range, (state_r == S_MUL) || (state_r == S_UPD), bitn_r <= MATCH_BIT)
endmodule

### tb/tb_lzma_literal_range_encoder_core.sv
// Self-checking testbench: literal range encoder against a cycle-free predictor of the coder
module tb_lzma_literal_range_encoder_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lzr_pkg::*;

  localparam int N_MATCH = 4;
  localparam int N_LIT = LIT_TREE_SIZE << 3;
  localparam logic [10:0] PROB_HALF = 11'd1024;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int HOLD_START = 10000;
  localparam int HOLD_LEN = 2500;

  typedef enum logic {OP_DATA = 1'b0, OP_FINISH = 1'b1} opcode_e;

  typedef struct packed {
    opcode_e    op;
    logic [7:0] data;
  } literal_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lzr_in_if  in_ch ();
  lzr_out_if out_ch ();

  lzma_literal_range_encoder_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  literal_cmd_t cmd_q[$];
  out_beat_t    emit_q[$];
  out_beat_t    item_emits[$];
  int           err_cnt = 0;
  int           cyc = 0;
  bit           took = 0;

  // coder state mirror
  logic [32:0] low;
  logic [31:0] rng;
  logic [7:0]  cache;
  logic [31:0] pend;
  logic [10:0] mprob [N_MATCH];
  logic [10:0] lprob [N_LIT];
  logic [7:0]  prev;
  logic [1:0]  pos;
  int          nemit;

  function automatic void coder_clear();
    low = '0;
    rng = RANGE_INIT;
    cache = '0;
    pend = 32'd1;
    for (int i = 0; i < N_MATCH; i++) mprob[i] = PROB_HALF;
    for (int i = 0; i < N_LIT; i++) lprob[i] = PROB_HALF;
    prev = '0;
    pos = '0;
  endfunction

  function automatic void shift_low();
    logic hi;
    out_beat_t b;
    hi = low[32];
    if (hi || low < 33'h0_FF00_0000) begin
      if (nemit < 9) begin
        b.res.lead_byte = cache + {7'd0, hi};
        b.res.fill_byte = hi ? FILL_CARRY : FILL_NO_CARRY;
        b.res.fill_count = (pend != 0) ? pend - 32'd1 : 32'd0;
        b.last_of_run = 1'b0;
        item_emits.insert(item_emits.size(), b);
        nemit++;
      end
      cache = low[31:24];
      pend = '0;
    end
    if (pend != PEND_MAX) pend = pend + 32'd1;
    low = {1'b0, low[23:0], 8'h00};
  endfunction

  function automatic logic [10:0] code_bit(logic [10:0] p, logic b);
    logic [31:0] bound;
    logic [11:0] pv;
    bound = (rng >> 11) * {21'd0, p};
    if (!b) begin
      rng = bound;
      pv = {1'b0, p} + ((12'd2048 - {1'b0, p}) >> 5);
    end else begin
      low = low + {1'b0, bound};
      rng = rng - bound;
      pv = {1'b0, p} - ({1'b0, p} >> 5);
    end
    while (rng < RANGE_TOP) begin
      rng = rng << 8;
      shift_low();
    end
    return pv[10:0];
  endfunction

  function automatic void predict_literal(literal_cmd_t c);
    int base;
    int ctx;
    int idx;
    logic v;
    nemit = 0;
    item_emits.delete();
    if (c.op == OP_FINISH) begin
      for (int i = 0; i < 5; i++) shift_low();
      coder_clear();
    end else begin
      mprob[pos] = code_bit(mprob[pos], 1'b0);
      base = LIT_TREE_SIZE * int'(prev >> 5);
      ctx = 1;
      for (int b = 7; b >= 0; b--) begin
        v = c.data[b];
        idx = base + ctx;
        if (idx < N_LIT) lprob[idx] = code_bit(lprob[idx], v);
        ctx = ((ctx << 1) | int'(v)) & 'h1FF;
      end
      prev = c.data;
      pos = pos + 2'd1;
    end
    if (item_emits.size() > 0) item_emits[item_emits.size() - 1].last_of_run = 1'b1;
    foreach (item_emits[i]) emit_q.insert(emit_q.size(), item_emits[i]);
  endfunction

  initial begin
    coder_clear();
    in_ch.valid = 1'b0;
    in_ch.opcode = 1'b0;
    in_ch.data_byte = 8'h00;
    out_ch.ready = 1'b0;
  end

  // input acceptance and prediction
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_literal(literal_cmd_t'({in_ch.opcode, in_ch.data_byte}));
      took = 1;
    end
  end

  // driver: bursts and gaps
  int burst = 0;
  int gap = 0;
  always @(negedge clk) begin
    if (took) begin
      took = 0;
      void'(cmd_q.pop_front());
      in_ch.valid = 1'b0;
    end
    if (!rst_n) begin
      in_ch.valid = 1'b0;
    end else if (!in_ch.valid) begin
      if (gap > 0) begin
        gap--;
      end else if (cmd_q.size() > 0) begin
        in_ch.valid = 1'b1;
        in_ch.opcode = cmd_q[0].op;
        in_ch.data_byte = cmd_q[0].data;
        if (burst > 0) begin
          burst--;
        end else begin
          burst = $urandom_range(0, 12);
          gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 5);
        end
      end
    end
  end

  // receiver stall pattern with one long hold-off, started while a beat is waiting
  int rmode = 0;
  int rcnt = 0;
  int hold_left = 0;
  bit hold_done = 0;
  always @(negedge clk) begin
    rcnt++;
    if (rcnt % 300 == 0) rmode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready = 1'b0;
    end else if (!hold_done && rcnt >= HOLD_START && out_ch.valid) begin
      hold_done = 1;
      hold_left = HOLD_LEN - 1;
      out_ch.ready = 1'b0;
    end else case (rmode)
      0: out_ch.ready = 1'b1;
      1: out_ch.ready = ($urandom_range(0, 9) < 7);
      2: out_ch.ready = ((rcnt % 11) > 6);
      default: out_ch.ready = ($urandom_range(0, 9) < 2);
    endcase
  end

  // result checking
  always @(posedge clk) begin
    out_beat_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (emit_q.size() == 0) begin
        $error("unexpected beat lead_byte=%0h", out_ch.lead_byte);
        err_cnt++;
      end else begin
        e = emit_q.pop_front();
        if (out_ch.lead_byte !== e.res.lead_byte) begin
          $error("lead_byte exp %0h got %0h", e.res.lead_byte, out_ch.lead_byte);
          err_cnt++;
        end
        if (out_ch.fill_byte !== e.res.fill_byte) begin
          $error("fill_byte exp %0h got %0h", e.res.fill_byte, out_ch.fill_byte);
          err_cnt++;
        end
        if (out_ch.fill_count !== e.res.fill_count) begin
          $error("fill_count exp %0d got %0d", e.res.fill_count, out_ch.fill_count);
          err_cnt++;
        end
        if (out_ch.last_of_run !== e.last_of_run) begin
          $error("last_of_run exp %0b got %0b", e.last_of_run, out_ch.last_of_run);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cyc >= CYCLE_LIMIT) begin
      $display("lzma_literal_range_encoder_core regression: fail");
      $finish;
    end
  end

  task automatic add_cmd(opcode_e op, logic [7:0] d);
    literal_cmd_t c;
    c.op = op;
    c.data = d;
    cmd_q.insert(cmd_q.size(), c);
  endtask

  initial begin
    int n;
    int k;
    logic [7:0] d;
    // directed
    add_cmd(OP_FINISH, 8'h5A);
    add_cmd(OP_DATA, 8'h00);
    add_cmd(OP_DATA, 8'hFF);
    add_cmd(OP_DATA, 8'h80);
    add_cmd(OP_DATA, 8'h7F);
    add_cmd(OP_DATA, 8'h01);
    add_cmd(OP_DATA, 8'hFE);
    for (int i = 0; i < 6; i++) add_cmd(OP_DATA, 8'h55 ^ i[7:0]);
    add_cmd(OP_FINISH, 8'hFF);
    add_cmd(OP_FINISH, 8'h00);
    for (int i = 0; i < 8; i++) add_cmd(OP_DATA, 8'h00);
    add_cmd(OP_FINISH, 8'hA5);
    // random
    n = 0;
    while (n < 385) begin
      k = $urandom_range(0, 99);
      if (k < 5) begin
        add_cmd(OP_FINISH, 8'($urandom));
        n++;
      end else if (k < 35) begin
        d = ($urandom_range(0, 1) == 0) ? 8'($urandom) : (($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF);
        k = $urandom_range(1, 16);
        for (int i = 0; i < k; i++) add_cmd(OP_DATA, d);
        n += k;
      end else begin
        add_cmd(OP_DATA, 8'($urandom));
        n++;
      end
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    while (cmd_q.size() > 0 || in_ch.valid) @(posedge clk);
    while (emit_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_cnt == 0 && emit_q.size() == 0) begin
      $display("lzma_literal_range_encoder_core regression: pass");
    end else begin
      $display("lzma_literal_range_encoder_core regression: fail");
    end
    $finish;
  end

endmodule
